/* sv/longest_unique_run_tracker_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the longest unique run tracker
// Each macro samples on the clock rising edge. The check is off while reset is high.
// ----------------------------------------------------------------------------
`ifndef LONGEST_UNIQUE_RUN_TRACKER_TOP_MACROS_SVH
`define LONGEST_UNIQUE_RUN_TRACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define LURT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LURT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/lurt_pkg.sv */
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared widths and control types for the longest unique run tracker.
// ----------------------------------------------------------------------------
package lurt_pkg;

   localparam int LEN_W = 17;   // reported length width
   localparam int SYM_W = 8;    // symbol width

   // position table commands
   typedef struct packed {
      logic rd_en;   // read at a new transaction's index
      logic wr_en;   // record position for the symbol being scored
      logic clear;   // end of string: drop all seen bits
   } tbl_ctrl_type;

endpackage

/* sv/lurt_table.sv */
// ----------------------------------------------------------------------------
// lurt_table
// Last-seen position memory with seen bits and last-write forwarding.
// ----------------------------------------------------------------------------
module lurt_table #(
   parameter int ENTRIES = 256,
   parameter int IDX_W   = 8,
   parameter int LP_W    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lurt_pkg::tbl_ctrl_type ctrl,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [IDX_W-1:0]      wr_idx,
   input  logic [LP_W-1:0]       wr_pos,
   input  logic [IDX_W-1:0]      lk_idx,
   output logic                  lk_seen,
   output logic [LP_W-1:0]       lk_pos
);

   logic [LP_W-1:0]    mem [ENTRIES];
   logic [LP_W-1:0]    rd_data_ff;
   logic [ENTRIES-1:0] seen_ff;
   logic [ENTRIES-1:0] seen_in;
   logic               fwd_en_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   logic [LP_W-1:0]    fwd_pos_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= wr_pos;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // most recent write; it covers a read issued on the same edge as that write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         fwd_en_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         fwd_idx_ff <= wr_idx;
         fwd_pos_ff <= wr_pos;
      end
   end

   // clear wins over the final write of a string
   always_comb begin
      seen_in = seen_ff;
      if (ctrl.clear) begin
         seen_in = '0;
      end else if (ctrl.wr_en) begin
         seen_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign lk_seen = seen_ff[lk_idx];
   assign lk_pos  = (fwd_en_ff && (fwd_idx_ff == lk_idx)) ? fwd_pos_ff : rd_data_ff;

endmodule

/* sv/longest_unique_run_tracker_top.sv */
// ----------------------------------------------------------------------------
// longest_unique_run_tracker_top
// Streaming longest-run-without-repeated-byte tracker, one byte per cycle while responses are taken.
// ----------------------------------------------------------------------------
// The block takes one byte per transaction and returns exactly one response
// for it: the longest repeat-free run so far in the current string. It sustains
// one transaction per clock while responses are taken. The position table is
// read on the accept edge, and the transaction is scored into the response
// register when the stage moves on. The rate is set by the single read port
// of the position memory. A write to an entry is forwarded to a transaction
// that read that entry on the same edge. The stage and the response register
// make a two-deep pipe. While the response waits to be taken, the block takes
// at most one more transaction into the stage and then stalls. A flagged last
// byte returns string_done with the final answer. The string state clears
// the cycle it is scored: one flop per table entry holds the seen bit, so
// there is no clearing pass after reset or between strings. Bytes past
// MAX_STRING_LEN positions are not entered in the table. They raise
// too_long and hold best_length until the string ends.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker_top #(
   parameter int MAX_STRING_LEN = 65536,
   parameter int ALPHABET_SIZE  = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lurt_pkg::SYM_W-1:0]   req_symbol,
   input  logic                         req_end_of_string,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lurt_pkg::LEN_W-1:0]   rsp_best_length,
   output logic                         rsp_string_done,
   output logic                         rsp_too_long
);

   localparam int IDX_W   = $clog2(ALPHABET_SIZE);
   localparam int LP_W    = $clog2(MAX_STRING_LEN);
   localparam int POS_W   = $clog2(MAX_STRING_LEN + 1);
   localparam int EXT_W   = (POS_W > lurt_pkg::LEN_W) ? POS_W : lurt_pkg::LEN_W;
   localparam int SYM_CNT = 2 ** lurt_pkg::SYM_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_LEN);

   // symbol to table index, folded into the alphabet at elaboration
   function automatic logic [SYM_CNT*IDX_W-1:0] fold_table();
      logic [SYM_CNT*IDX_W-1:0] tab;
      tab = '0;
      for (int i = 0; i < SYM_CNT; i++) begin
         tab[i*IDX_W +: IDX_W] = IDX_W'(i % ALPHABET_SIZE);
      end
      return tab;
   endfunction

   localparam logic [SYM_CNT*IDX_W-1:0] FOLD = fold_table();

   // handshake
   logic req_accept;
   logic s1_adv;

   // scoring stage
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff,   s1_idx_in;
   logic             s1_eos_ff,   s1_eos_in;
   logic [IDX_W-1:0] req_idx;

   // per-string state; lb1 holds left bound plus one, so it starts at zero
   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [POS_W-1:0] lb1_ff,  lb1_in;
   logic [POS_W-1:0] best_ff, best_in;
   logic             ovf_ff,  ovf_in;

   // scoring datapath
   logic                   in_range;
   logic                   lk_seen;
   logic [LP_W-1:0]        lk_pos;
   logic [POS_W-1:0]       lp_ext;
   logic [POS_W-1:0]       lb1_new;
   logic [POS_W-1:0]       pos_next;
   logic [POS_W-1:0]       run_len;
   logic [POS_W-1:0]       best_new;
   logic                   ovf_new;
   logic [EXT_W-1:0]       best_ext;
   lurt_pkg::tbl_ctrl_type tbl_ctrl;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lurt_pkg::LEN_W-1:0] rsp_best_ff,  rsp_best_in;
   logic                       rsp_done_ff,  rsp_done_in;
   logic                       rsp_tl_ff,    rsp_tl_in;

   // --- handshake ---------------------------------------------------------
   // The stage moves on when the response register is empty or being drained.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;
   assign req_idx    = FOLD[req_symbol*IDX_W +: IDX_W];

   // --- position table ----------------------------------------------------
   always_comb begin
      tbl_ctrl.rd_en = req_accept;
      tbl_ctrl.wr_en = s1_adv && in_range;
      tbl_ctrl.clear = s1_adv && s1_eos_ff;
   end

   lurt_table #(
      .ENTRIES (ALPHABET_SIZE),
      .IDX_W   (IDX_W),
      .LP_W    (LP_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tbl_ctrl),
      .rd_idx  (req_idx),
      .wr_idx  (s1_idx_ff),
      .wr_pos  (pos_ff[LP_W-1:0]),
      .lk_idx  (s1_idx_ff),
      .lk_seen (lk_seen),
      .lk_pos  (lk_pos)
   );

   // --- scoring -----------------------------------------------------------
   // A hit inside the window (last seen at or after lb1) pulls the bound up.
   always_comb begin
      in_range = pos_ff < POS_LIMIT;
      lp_ext   = POS_W'(lk_pos);
      pos_next = pos_ff + POS_W'(1);
      if (lk_seen && (lp_ext >= lb1_ff)) begin
         lb1_new = lp_ext + POS_W'(1);
      end else begin
         lb1_new = lb1_ff;
      end
      run_len = pos_next - lb1_new;
      if (in_range && (run_len > best_ff)) begin
         best_new = run_len;
      end else begin
         best_new = best_ff;
      end
      ovf_new  = ovf_ff || !in_range;
      best_ext = EXT_W'(best_new);
   end

   // --- stage and string state --------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_idx_in   = s1_idx_ff;
      s1_eos_in   = s1_eos_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_idx_in   = req_idx;
         s1_eos_in   = req_end_of_string;
      end

      pos_in  = pos_ff;
      lb1_in  = lb1_ff;
      best_in = best_ff;
      ovf_in  = ovf_ff;
      if (s1_adv) begin
         if (s1_eos_ff) begin
            pos_in  = '0;
            lb1_in  = '0;
            best_in = '0;
            ovf_in  = 1'b0;
         end else begin
            if (in_range) begin
               pos_in = pos_next;
               lb1_in = lb1_new;
            end
            best_in = best_new;
            ovf_in  = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
         lb1_ff      <= '0;
         best_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff      <= pos_in;
         lb1_ff      <= lb1_in;
         best_ff     <= best_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= s1_idx_in;
      s1_eos_ff <= s1_eos_in;
   end

   // --- response register -------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_best_in  = rsp_best_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_tl_in    = rsp_tl_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = best_ext[lurt_pkg::LEN_W-1:0];
         rsp_done_in  = s1_eos_ff;
         rsp_tl_in    = ovf_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff <= rsp_best_in;
      rsp_done_ff <= rsp_done_in;
      rsp_tl_ff   <= rsp_tl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_best_ff;
   assign rsp_string_done = rsp_done_ff;
   assign rsp_too_long    = rsp_tl_ff;

endmodule

/* sv/lurt_checker.sv */
// ----------------------------------------------------------------------------
// lurt_checker
// Port-level checks for the longest unique run tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "longest_unique_run_tracker_top_macros.svh"

module lurt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [lurt_pkg::LEN_W-1:0] rsp_best_length,
   input logic                       rsp_string_done,
   input logic                       rsp_too_long
);

   logic                       req_acc;
   logic                       rsp_acc;
   logic [1:0]                 pending_ff, pending_in;
   logic                       open_tl_ff, open_tl_in;   // string still open, overflowed
   logic [lurt_pkg::LEN_W-1:0] prev_best_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + 2'(req_acc) - 2'(rsp_acc);
      open_tl_in = open_tl_ff;
      if (rsp_acc) begin
         open_tl_in = rsp_too_long && !rsp_string_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         open_tl_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         open_tl_ff <= open_tl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         prev_best_ff <= rsp_best_length;
      end
   end

   `LURT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_best_length) && $stable(rsp_string_done) && $stable(rsp_too_long), "response dropped or changed while stalled")
   `LURT_ASSERT_SAME(a_rsp_has_req, rsp_valid, pending_ff != 2'd0, "response without an outstanding request")
   `LURT_ASSERT_SAME(a_tl_sticky, rsp_valid && open_tl_ff, rsp_too_long, "too_long cleared before end of string")
   `LURT_ASSERT_SAME(a_tl_frozen, rsp_valid && open_tl_ff, rsp_best_length == prev_best_ff, "best_length moved after overflow")

endmodule

bind longest_unique_run_tracker_top lurt_checker u_lurt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_best_length (rsp_best_length),
   .rsp_string_done (rsp_string_done),
   .rsp_too_long    (rsp_too_long)
);
